// ===== hdl/a85_pkg.sv =====
package a85_pkg;

    localparam int A85_QUEUE_DEPTH = 4;

    localparam logic [1:0] A85_KIND_BYTE   = 2'd0;
    localparam logic [1:0] A85_KIND_ACCEPT = 2'd1;
    localparam logic [1:0] A85_KIND_REJECT = 2'd2;

    localparam logic [7:0] A85_CHAR_FIRST = 8'h21;  // '!'
    localparam logic [7:0] A85_CHAR_LAST  = 8'h75;  // 'u'
    localparam logic [7:0] A85_CHAR_Z     = 8'h7A;  // 'z'

    localparam logic [31:0] A85_BASE = 32'd85;

    localparam logic [2:0] A85_GROUP_LAST = 3'd4;

    // Work handed from the front to the back: bytes to send from word,
    // most significant first, then optionally an end-of-string marker.
    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  nbytes;
        logic        marker;
        logic        reject;
    } a85_job_t;

    // Padding a group of n digits with 84s equals v*85^(5-n) + 85^(5-n) - 1.
    function automatic logic [31:0] a85_pad_factor(input logic [2:0] count);
        logic [31:0] f;
        begin
            case (count)
                3'd2:    f = 32'd614125;
                3'd3:    f = 32'd7225;
                3'd4:    f = 32'd85;
                default: f = 32'd1;
            endcase
            return f;
        end
    endfunction

endpackage

// ===== hdl/a85_front.sv =====
module a85_front
    import a85_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_action,
    input  logic [7:0]  s_char_code,
    output logic        push_valid,
    output a85_job_t    push_job,
    input  logic        push_ready
);

    logic [31:0] group_value_reg, group_value_next;
    logic [2:0]  digit_count_reg, digit_count_next;
    logic        rejected_reg, rejected_next;

    logic        accept;
    logic        is_space, is_digit, is_z;
    logic [6:0]  digit;
    logic [7:0]  char_off;
    logic [31:0] factor, addend, mac;

    assign s_ready = push_ready;
    assign accept  = s_valid && s_ready;

    always_comb begin
        is_space = s_char_code inside {8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
        is_digit = s_char_code inside {[A85_CHAR_FIRST:A85_CHAR_LAST]};
        is_z     = (s_char_code == A85_CHAR_Z);
        char_off = s_char_code - A85_CHAR_FIRST;
        digit    = char_off[6:0];
    end

    // one shared multiply-add: a digit step or the whole end-of-string padding
    always_comb begin
        if (s_action) begin
            factor = a85_pad_factor(digit_count_reg);
            addend = factor - 32'd1;
        end else begin
            factor = A85_BASE;
            addend = {25'd0, digit};
        end
        mac = group_value_reg * factor + addend;
    end

    always_comb begin
        group_value_next = group_value_reg;
        digit_count_next = digit_count_reg;
        rejected_next    = rejected_reg;
        push_valid       = 1'b0;
        push_job         = '0;
        if (accept) begin
            if (s_action) begin
                push_valid       = 1'b1;
                push_job.marker  = 1'b1;
                if (rejected_reg || digit_count_reg == 3'd1) begin
                    push_job.reject = 1'b1;
                end else if (digit_count_reg > 3'd1) begin
                    push_job.word   = mac;
                    push_job.nbytes = digit_count_reg - 3'd1;
                end
                group_value_next = '0;
                digit_count_next = '0;
                rejected_next    = 1'b0;
            end else if (!rejected_reg && !is_space) begin
                if (is_z && digit_count_reg == 3'd0) begin
                    push_valid      = 1'b1;
                    push_job.nbytes = 3'd4;
                end else if (!is_digit) begin
                    rejected_next = 1'b1;
                end else if (digit_count_reg == A85_GROUP_LAST) begin
                    push_valid       = 1'b1;
                    push_job.word    = mac;
                    push_job.nbytes  = 3'd4;
                    group_value_next = '0;
                    digit_count_next = '0;
                end else begin
                    group_value_next = mac;
                    digit_count_next = digit_count_reg + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            group_value_reg <= '0;
            digit_count_reg <= '0;
            rejected_reg    <= 1'b0;
        end else begin
            group_value_reg <= group_value_next;
            digit_count_reg <= digit_count_next;
            rejected_reg    <= rejected_next;
        end
    end

`ifndef ASSERT_OFF
    a_flush_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_action) |=> (digit_count_reg == 3'd0 && !rejected_reg
                                  && group_value_reg == 32'd0))
        else $error("state not cleared after end of string");
    a_push_needs_request: assert property (@(posedge aclk) disable iff (!aresetn)
        push_valid |-> (accept && (s_action || !rejected_reg)))
        else $error("job pushed without an accepted request");
    a_group_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !s_action && digit_count_reg == A85_GROUP_LAST && is_digit
         && !rejected_reg) |-> (push_valid && push_job.nbytes == 3'd4))
        else $error("full group did not emit four bytes");
`endif

endmodule

// ===== hdl/a85_queue.sv =====
module a85_queue
    import a85_pkg::*;
#(
    parameter int DEPTH = A85_QUEUE_DEPTH
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push_valid,
    output logic     push_ready,
    input  a85_job_t push_job,
    output logic     pop_valid,
    input  logic     pop_ready,
    output a85_job_t pop_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    a85_job_t         entries_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CNT_FULL);
    assign pop_valid  = (count_reg != '0);
    assign pop_job    = entries_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entries_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ===== hdl/a85_back.sv =====
module a85_back
    import a85_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       pop_valid,
    output logic       pop_ready,
    input  a85_job_t   pop_job,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_data_byte,
    output logic [1:0] m_kind,
    output logic       m_last_in_run
);

    logic        job_valid_reg, job_valid_next;
    logic [31:0] job_word_reg, job_word_next;
    logic [2:0]  job_left_reg, job_left_next;
    logic        job_marker_reg, job_marker_next;
    logic        job_reject_reg, job_reject_next;

    logic        m_valid_reg, m_valid_next;
    logic [7:0]  m_data_byte_reg, m_data_byte_next;
    logic [1:0]  m_kind_reg, m_kind_next;
    logic        m_last_reg, m_last_next;

    logic out_free, job_take, job_done, emit_byte, res_last;

    assign out_free  = !m_valid_reg || m_ready;
    assign job_take  = out_free && job_valid_reg;
    assign emit_byte = (job_left_reg != 3'd0);
    assign res_last  = emit_byte ? (job_left_reg == 3'd1 && !job_marker_reg) : 1'b1;
    assign job_done  = job_take && res_last;
    assign pop_ready = !job_valid_reg || job_done;

    always_comb begin
        job_valid_next  = job_valid_reg;
        job_word_next   = job_word_reg;
        job_left_next   = job_left_reg;
        job_marker_next = job_marker_reg;
        job_reject_next = job_reject_reg;
        if (pop_valid && pop_ready) begin
            job_valid_next  = 1'b1;
            job_word_next   = pop_job.word;
            job_left_next   = pop_job.nbytes;
            job_marker_next = pop_job.marker;
            job_reject_next = pop_job.reject;
        end else if (job_done) begin
            job_valid_next = 1'b0;
        end else if (job_take) begin
            job_word_next = {job_word_reg[23:0], 8'd0};
            job_left_next = job_left_reg - 3'd1;
        end
    end

    always_comb begin
        m_valid_next     = m_valid_reg;
        m_data_byte_next = m_data_byte_reg;
        m_kind_next      = m_kind_reg;
        m_last_next      = m_last_reg;
        if (out_free) begin
            m_valid_next     = job_valid_reg;
            m_data_byte_next = emit_byte ? job_word_reg[31:24] : 8'd0;
            m_last_next      = res_last;
            if (emit_byte) begin
                m_kind_next = A85_KIND_BYTE;
            end else if (job_reject_reg) begin
                m_kind_next = A85_KIND_REJECT;
            end else begin
                m_kind_next = A85_KIND_ACCEPT;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            job_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            job_valid_reg <= job_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        job_word_reg    <= job_word_next;
        job_left_reg    <= job_left_next;
        job_marker_reg  <= job_marker_next;
        job_reject_reg  <= job_reject_next;
        m_data_byte_reg <= m_data_byte_next;
        m_kind_reg      <= m_kind_next;
        m_last_reg      <= m_last_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_data_byte   = m_data_byte_reg;
    assign m_kind        = m_kind_reg;
    assign m_last_in_run = m_last_reg;

`ifndef ASSERT_OFF
    a_marker_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_kind != A85_KIND_BYTE) |-> (m_last_in_run && m_data_byte == 8'd0))
        else $error("end-of-string marker not last of its run");
    a_run_continues: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last_in_run) |=> m_valid)
        else $error("run broken before its last result");
    a_idle_job_no_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (!job_valid_reg && m_valid && m_ready) |=> !m_valid)
        else $error("result produced without a job");
`endif

endmodule

// ===== hdl/ascii85_stream_decoder.sv =====
// Path: a request's results pass through the queue, the back end's job register, then the output register.
// Throughput: one request per cycle while the queue has room; the back end sends one
//   result per cycle while m_ready is high, a group or 'z' giving four results and a
//   flush up to four; the queue absorbs bursts, but a run of 'z' is held to that rate.
// Each request uses one constant multiply-add in the front end, the design's only multiplier.
// Reset: aresetn synchronous, active low; clears decoder state, queue and output valid.
module ascii85_stream_decoder
    import a85_pkg::*;
#(
    parameter int QUEUE_DEPTH = A85_QUEUE_DEPTH
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_action,
    input  logic [7:0] s_char_code,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_data_byte,
    output logic [1:0] m_kind,
    output logic       m_last_in_run
);

    logic     push_valid, push_ready, pop_valid, pop_ready;
    a85_job_t push_job, pop_job;

    a85_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_action    (s_action),
        .s_char_code (s_char_code),
        .push_valid  (push_valid),
        .push_job    (push_job),
        .push_ready  (push_ready)
    );

    a85_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job)
    );

    a85_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .pop_valid     (pop_valid),
        .pop_ready     (pop_ready),
        .pop_job       (pop_job),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data_byte   (m_data_byte),
        .m_kind        (m_kind),
        .m_last_in_run (m_last_in_run)
    );

endmodule

// ===== sim/testbench.sv =====
module testbench
    import a85_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic       action;
        logic [7:0] ch;
    } dec_request_t;

    typedef struct packed {
        logic [7:0] data;
        logic [1:0] kind;
        logic       last;
    } dec_result_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic       s_action = 1'b0;
    logic [7:0] s_char_code = 8'h00;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_data_byte;
    logic [1:0] m_kind;
    logic       m_last_in_run;

    ascii85_stream_decoder dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_action     (s_action),
        .s_char_code  (s_char_code),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data_byte  (m_data_byte),
        .m_kind       (m_kind),
        .m_last_in_run(m_last_in_run)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    dec_request_t pending_requests[$];
    dec_result_t  decoded_q[$];

    // decoder state as the testbench sees it
    logic [31:0] grp_val = '0;
    logic [2:0]  grp_cnt = '0;
    logic        str_rejected = 1'b0;

    logic [7:0] blank_chars [6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};

    int  mismatches = 0;
    int  requests_taken = 0;
    int  bytes_seen = 0;
    int  accepts_seen = 0;
    int  rejects_seen = 0;
    int  counted_requests = 0;
    logic in_fire = 1'b0;

    task automatic report_mismatch(input string what, input dec_result_t want,
                                   input dec_result_t got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t %s: expected byte %02h kind %0d last %0b, got byte %02h kind %0d last %0b",
                     $realtime, what, want.data, want.kind, want.last,
                     got.data, got.kind, got.last);
    endtask

    task automatic decode_request(input logic act, input logic [7:0] ch);
        dec_result_t res[$];
        logic [31:0] v;
        int k;
        if (act) begin
            if (!str_rejected && grp_cnt == 3'd1)
                str_rejected = 1'b1;
            if (!str_rejected && grp_cnt > 3'd1) begin
                // pad the partial group with the top digit
                v = grp_val;
                for (k = grp_cnt; k < 5; k++)
                    v = v * A85_BASE + 32'd84;
                for (k = 0; k + 1 < grp_cnt; k++)
                    res.push_back('{v[31 - 8 * k -: 8], A85_KIND_BYTE, 1'b0});
            end
            res.push_back('{8'h00, str_rejected ? A85_KIND_REJECT : A85_KIND_ACCEPT, 1'b0});
            grp_val = '0;
            grp_cnt = '0;
            str_rejected = 1'b0;
        end else if (!str_rejected && !(ch inside {8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D}))
        begin
            if (ch == A85_CHAR_Z && grp_cnt == 3'd0) begin
                for (k = 0; k < 4; k++)
                    res.push_back('{8'h00, A85_KIND_BYTE, 1'b0});
            end else if (ch < A85_CHAR_FIRST || ch > A85_CHAR_LAST) begin
                str_rejected = 1'b1;
            end else begin
                grp_val = grp_val * A85_BASE + 32'(ch - A85_CHAR_FIRST);
                grp_cnt = grp_cnt + 3'd1;
                if (grp_cnt > A85_GROUP_LAST) begin
                    for (k = 0; k < 4; k++)
                        res.push_back('{grp_val[31 - 8 * k -: 8], A85_KIND_BYTE, 1'b0});
                    grp_val = '0;
                    grp_cnt = '0;
                end
            end
        end
        if (res.size() > 0)
            res[res.size() - 1].last = 1'b1;
        foreach (res[i])
            decoded_q.push_back(res[i]);
    endtask

    // monitor: results first, then the request taken at this edge
    always @(posedge aclk) begin
        dec_result_t got;
        dec_result_t want;
        if (!aresetn) begin
            in_fire <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                got = '{m_data_byte, m_kind, m_last_in_run};
                if (m_kind == A85_KIND_BYTE)
                    bytes_seen++;
                else if (m_kind == A85_KIND_ACCEPT)
                    accepts_seen++;
                else
                    rejects_seen++;
                if (decoded_q.size() == 0) begin
                    report_mismatch("unexpected result", '0, got);
                end else begin
                    want = decoded_q.pop_front();
                    if (got.data !== want.data || got.kind !== want.kind ||
                        got.last !== want.last)
                        report_mismatch("result differs", want, got);
                end
            end
            in_fire <= s_valid && s_ready;
            if (s_valid && s_ready) begin
                requests_taken++;
                decode_request(s_action, s_char_code);
            end
        end
    end

    // sender: bursts of requests with random gaps between them
    int burst_left = 0;
    int gap_left = 0;

    always @(negedge aclk) begin
        dec_request_t req;
        logic nv;
        if (aresetn && (!s_valid || in_fire)) begin
            nv = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (pending_requests.size() > 0) begin
                req = pending_requests.pop_front();
                s_action <= req.action;
                s_char_code <= req.ch;
                nv = 1'b1;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
                end else begin
                    burst_left--;
                end
            end
            s_valid <= nv;
        end
    end

    // receiver: rotating ready pattern, reloaded now and then
    logic [15:0] ready_pat = 16'hFFFF;
    int          pat_left = 0;

    always @(negedge aclk) begin
        if (pat_left == 0) begin
            case ($urandom_range(0, 3))
                0: ready_pat = 16'hFFFF;
                1: ready_pat = 16'($urandom);
                2: ready_pat = 16'($urandom | $urandom);
                default: ready_pat = 16'($urandom & $urandom);
            endcase
            pat_left = $urandom_range(16, 96);
        end else begin
            pat_left--;
        end
        m_ready <= ready_pat[0];
        ready_pat = {ready_pat[0], ready_pat[15:1]};
    end

    task automatic queue_request(input logic act, input logic [7:0] ch);
        pending_requests.push_back('{act, ch});
        if (act || !(ch inside {8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D}))
            counted_requests++;
    endtask

    task automatic queue_char(input logic [7:0] ch, input bit noisy);
        if (!noisy && $urandom_range(0, 9) == 0)
            queue_request(1'b0, blank_chars[$urandom_range(0, 5)]);
        if (noisy && $urandom_range(0, 5) == 0)
            ch = 8'($urandom_range(0, 255));
        queue_request(1'b0, ch);
    endtask

    initial begin
        bit noisy;
        bit hot;
        int ngroups;
        int tail;
        // empty string
        queue_request(1'b1, 8'h00);
        // whitespace, 'z' at a boundary, then an overflowing group
        queue_request(1'b0, 8'h0D);
        queue_request(1'b0, A85_CHAR_Z);
        repeat (5) queue_request(1'b0, A85_CHAR_LAST);
        queue_request(1'b1, 8'hFF);
        // lowest digits, two-digit tail
        queue_request(1'b0, A85_CHAR_FIRST);
        queue_request(1'b0, A85_CHAR_FIRST);
        queue_request(1'b1, 8'h00);
        // four-digit tail that overflows while padding
        queue_request(1'b0, A85_CHAR_LAST);
        queue_request(1'b0, 8'h0A);
        repeat (3) queue_request(1'b0, A85_CHAR_LAST);
        queue_request(1'b1, 8'h00);
        // lone leftover digit
        queue_request(1'b0, A85_CHAR_LAST);
        queue_request(1'b1, 8'h00);
        // 'z' inside a group, then ignored characters
        queue_request(1'b0, A85_CHAR_FIRST);
        queue_request(1'b0, A85_CHAR_Z);
        queue_request(1'b0, 8'hFF);
        queue_request(1'b1, 8'h00);
        // out-of-range byte at the bottom
        queue_request(1'b0, 8'h00);
        queue_request(1'b1, 8'h00);

        while (counted_requests < 470) begin
            noisy = ($urandom_range(0, 4) == 0);
            ngroups = $urandom_range(0, 3);
            for (int g = 0; g < ngroups; g++) begin
                if ($urandom_range(0, 5) == 0) begin
                    queue_char(A85_CHAR_Z, noisy);
                end else begin
                    hot = ($urandom_range(0, 3) == 0);
                    for (int d = 0; d < 5; d++)
                        queue_char(hot ? 8'($urandom_range(8'h72, 8'h75))
                                       : 8'($urandom_range(8'h21, 8'h75)), noisy);
                end
            end
            tail = $urandom_range(0, 4);
            if (!noisy && tail == 1)
                tail = 2;
            for (int d = 0; d < tail; d++)
                queue_char(8'($urandom_range(8'h21, 8'h75)), noisy);
            queue_request(1'b1, 8'($urandom_range(0, 255)));
        end

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        do @(posedge aclk); while (pending_requests.size() != 0 || s_valid);
        while (decoded_q.size() != 0)
            @(posedge aclk);
        repeat (10) @(posedge aclk);

        foreach (decoded_q[i])
            report_mismatch("result missing", decoded_q[i], '0);
        $display("%0d requests sent; %0d bytes, %0d accepted and %0d rejected strings checked",
                 requests_taken, bytes_seen, accepts_seen, rejects_seen);
        $display("%0d mismatches", mismatches);
        if (mismatches == 0)
            $display("ascii85_stream_decoder: match");
        else
            $display("ascii85_stream_decoder: mismatch");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("ascii85_stream_decoder: mismatch");
        $finish;
    end

endmodule

// ===== ascii85_stream_decoder.f =====
hdl/a85_pkg.sv
hdl/a85_front.sv
hdl/a85_queue.sv
hdl/a85_back.sv
hdl/ascii85_stream_decoder.sv
sim/testbench.sv
